@@ design/typed_value_to_double_unit_defines.svh @@
// Assertion macros for the typed value to double unit.
`ifndef TYPED_VALUE_TO_DOUBLE_UNIT_DEFINES_SVH
`define TYPED_VALUE_TO_DOUBLE_UNIT_DEFINES_SVH

// Assert that an implication holds at every clock edge outside reset.
`define TVD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Assert that an implication holds in the cycle after the antecedent.
`define TVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/tvd_pkg.sv @@
// ----------------------------------------------------------------------------
// tvd_pkg
// Type codes and shared helpers for the typed value to double unit.
// ----------------------------------------------------------------------------
package tvd_pkg;

   typedef enum logic [2:0] {
      TYPE_INT8    = 3'd0,
      TYPE_UINT8   = 3'd1,
      TYPE_INT16   = 3'd2,
      TYPE_UINT16  = 3'd3,
      TYPE_INT32   = 3'd4,
      TYPE_UINT32  = 3'd5,
      TYPE_FLOAT32 = 3'd6,
      TYPE_FLOAT64 = 3'd7
   } value_type_type;

   localparam logic [10:0] EXP_BIAS = 11'd1023;
   localparam logic [10:0] EXP_ONES = 11'h7FF;

   // Position of the highest set bit; 0 for zero.
   function automatic logic [5:0] msb_index(input logic [32:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 33; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

endpackage

@@ design/tvd_unpack.sv @@
// ----------------------------------------------------------------------------
// tvd_unpack
// Selects the value bytes by type and applies the optional byte swap.
// ----------------------------------------------------------------------------
module tvd_unpack import tvd_pkg::*; (
   input  logic [63:0]    raw_bytes,
   input  value_type_type value_type,
   input  logic           swap_bytes,
   output logic [63:0]    value
);

   always_comb begin
      value = 64'd0;
      case (value_type)
         TYPE_INT8, TYPE_UINT8: begin
            value[7:0] = raw_bytes[7:0];
         end
         TYPE_INT16, TYPE_UINT16: begin
            value[15:0] = swap_bytes ? {raw_bytes[7:0], raw_bytes[15:8]} : raw_bytes[15:0];
         end
         TYPE_INT32, TYPE_UINT32, TYPE_FLOAT32: begin
            for (int k = 0; k < 4; k++) begin
               value[8*k +: 8] = swap_bytes ? raw_bytes[8*(3-k) +: 8] : raw_bytes[8*k +: 8];
            end
         end
         default: begin
            for (int k = 0; k < 8; k++) begin
               value[8*k +: 8] = swap_bytes ? raw_bytes[8*(7-k) +: 8] : raw_bytes[8*k +: 8];
            end
         end
      endcase
   end

endmodule

@@ design/tvd_convert.sv @@
// ----------------------------------------------------------------------------
// tvd_convert
// Converts an unpacked integer or float value to binary64 bits.
// ----------------------------------------------------------------------------
module tvd_convert import tvd_pkg::*; (
   input  logic [63:0]    value,
   input  value_type_type value_type,
   output logic [63:0]    double_bits
);

   logic        neg;
   logic [32:0] mag;
   logic [5:0]  p;
   logic [84:0] shifted;
   logic [63:0] int_bits;
   logic        f_sign;
   logic [7:0]  f_exp;
   logic [22:0] f_frac;
   logic [5:0]  fp;
   logic [75:0] f_shifted;
   logic [63:0] flt_bits;

   always_comb begin
      neg = 1'b0;
      mag = {1'b0, value[31:0]};
      case (value_type)
         TYPE_INT8: begin
            neg = value[7];
            mag = neg ? 33'(9'h100 - {1'b0, value[7:0]}) : 33'(value[7:0]);
         end
         TYPE_INT16: begin
            neg = value[15];
            mag = neg ? 33'(17'h10000 - {1'b0, value[15:0]}) : 33'(value[15:0]);
         end
         TYPE_INT32: begin
            neg = value[31];
            mag = neg ? (33'h100000000 - {1'b0, value[31:0]}) : {1'b0, value[31:0]};
         end
         default: begin
            neg = 1'b0;
            mag = {1'b0, value[31:0]};
         end
      endcase
   end

   assign p        = msb_index(mag);
   assign shifted  = {52'd0, mag} << (6'd52 - p);
   assign int_bits = (mag == 33'd0) ? 64'd0 :
                     {neg, EXP_BIAS + 11'(p), shifted[51:0]};

   assign f_sign    = value[31];
   assign f_exp     = value[30:23];
   assign f_frac    = value[22:0];
   assign fp        = msb_index({10'd0, f_frac});
   assign f_shifted = {53'd0, f_frac} << (6'd52 - fp);

   always_comb begin
      if (f_exp == 8'd0) begin
         if (f_frac == 23'd0) begin
            flt_bits = {f_sign, 63'd0};
         end else begin
            flt_bits = {f_sign, 11'(fp) + 11'd874, f_shifted[51:0]};
         end
      end else if (f_exp == 8'hFF) begin
         if (f_frac == 23'd0) begin
            flt_bits = {f_sign, EXP_ONES, 52'd0};
         end else begin
            flt_bits = {f_sign, EXP_ONES, 1'b1, f_frac[21:0], 29'd0};
         end
      end else begin
         flt_bits = {f_sign, 11'(f_exp) + 11'd896, f_frac, 29'd0};
      end
   end

   always_comb begin
      case (value_type)
         TYPE_FLOAT32: double_bits = flt_bits;
         TYPE_FLOAT64: double_bits = value;
         default:      double_bits = int_bits;
      endcase
   end

endmodule

@@ design/typed_value_to_double_unit.sv @@
// ----------------------------------------------------------------------------
// typed_value_to_double_unit
// Converts one typed mesh property value to IEEE binary64 bits.
// ----------------------------------------------------------------------------
// One request per cycle is accepted while the output is not stalled. An
// accepted request lands in the input register, and its result is then
// loaded into the result register, which drives rsp_valid and
// rsp_double_bits; a stalled output holds the result register. The
// conversion path between the two registers sets the clock.
module typed_value_to_double_unit import tvd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_raw_bytes,
   input  logic [2:0]  req_value_type,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_double_bits,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   logic           swap_ff;
   logic           in_valid_ff;
   logic [63:0]    raw_ff;
   value_type_type type_ff;
   logic           out_valid_ff;
   logic [63:0]    out_ff;
   logic           adv_out;
   logic           adv_in;
   logic [63:0]    value;
   logic [63:0]    bits_in;

   assign adv_out   = !out_valid_ff || rsp_ready;
   assign adv_in    = !in_valid_ff || adv_out;
   assign req_ready = adv_in;
   assign rsp_valid = out_valid_ff;
   assign rsp_double_bits = out_ff;

   tvd_unpack u_unpack (
      .raw_bytes  (raw_ff),
      .value_type (type_ff),
      .swap_bytes (swap_ff),
      .value      (value)
   );

   tvd_convert u_convert (
      .value       (value),
      .value_type  (type_ff),
      .double_bits (bits_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff      <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            swap_ff <= csr_write_data;
         end
         if (adv_in) begin
            in_valid_ff <= req_valid;
         end
         if (adv_out) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in && req_valid) begin
         raw_ff  <= req_raw_bytes;
         type_ff <= value_type_type'(req_value_type);
      end
      if (adv_out && in_valid_ff) begin
         out_ff <= bits_in;
      end
   end

endmodule

@@ design/tvd_checker.sv @@
// ----------------------------------------------------------------------------
// tvd_checker
// Port-level checks for the typed value to double unit.
// ----------------------------------------------------------------------------
`include "typed_value_to_double_unit_defines.svh"

module tvd_checker import tvd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_value_type,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_double_bits
);

   `TVD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_double_bits))
   `TVD_ASSERT_IMPL(a_ready_free, clock, reset, !rsp_valid, req_ready)
   `TVD_ASSERT_IMPL(a_rsp_known, clock, reset, rsp_valid, !$isunknown(rsp_double_bits))
   `TVD_ASSERT_NEXT(a_f64_pass, clock, reset,
      req_valid && req_ready && rsp_ready && req_value_type == TYPE_FLOAT64,
      ##1 rsp_valid)

endmodule

bind typed_value_to_double_unit tvd_checker u_tvd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_value_type  (req_value_type),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_double_bits (rsp_double_bits)
);
